### rtl/vgrw_pkg.sv
`default_nettype none
package vgrw_pkg;
    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 16;
    localparam int GRID_Z_DEF = 16;
    localparam int RESULT_CAP = 46;
    localparam int T_W = 48;
    localparam logic [T_W-1:0] T_SAT = {T_W{1'b1}};
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WMIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WMIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WMIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CS_Z = 3'd5;

    // divide operations, run in this order
    localparam logic [2:0] OP_CELL = 3'd0;
    localparam logic [2:0] OP_TMAX = 3'd1;
    localparam logic [2:0] OP_TDEL = 3'd2;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture ray, compute diffs
        logic       div_start; // start one divide
        logic [2:0] div_op;    // start cell, tmax or tdelta of axis in div_axis
        logic [1:0] div_axis;
        logic       walk_step; // advance cell along chosen axis
        logic       emit;      // load output register
        logic       emit_out;  // emit flagged outside result
    } vgrw_cmd_t;

    typedef struct packed {
        logic div_done;
        logic outside;     // after cell divides
        logic fin;         // current cell is last
        logic out_busy;    // output register full and not taken
    } vgrw_sts_t;
endpackage
`default_nettype wire

### rtl/voxel_grid_ray_walker_top.sv
`default_nettype none
// 3d dda voxel walker: each ray transaction yields the start cell and every cell it
// enters, one result transaction each, last flag on the final one; an origin outside
// the grid yields one flagged result with zero cell fields. setup runs nine serial
// divides (start cell, tmax, tdelta per axis), each a start then 64 quotient bits and
// done, then one cell per cycle while the receiver takes them, up to 46 cells. a ray
// is taken only in idle, setup starts in the cycle after, and the next ray is taken
// once its last cell is loaded; an outside ray costs three divides and one result.
// the shared divider sets the rate, receiver stalls add to it. one ray at a time.
module voxel_grid_ray_walker_top #(
    parameter int GRID_X = vgrw_pkg::GRID_X_DEF,
    parameter int GRID_Y = vgrw_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vgrw_pkg::GRID_Z_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_idx,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cell_x, cell_y, cell_z, cell_index
    output logic [23:0]       m_tdata,
    // origin_outside
    output logic              m_tuser,
    output logic              m_tlast
);
    import vgrw_pkg::*;

    vgrw_cmd_t   cmd;
    vgrw_sts_t   sts;
    logic [25:0] md;

    vgrw_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    vgrw_datapath #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .ray(s_tdata), .cmd(cmd), .sts(sts),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(md)
    );

    // output register: cells and index low, outside flag, then last
    assign m_tdata = md[23:0];
    assign m_tuser = md[24];
    assign m_tlast = md[25];

    // a stalled result transaction holds still
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))) else $error("result changed while stalled");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser |-> m_tlast)) else $error("outside result not last");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser |-> m_tdata == '0)) else $error("outside result not zero");
endmodule
`default_nettype wire

### rtl/vgrw_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, 64 by 32
module vgrw_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [63:0]      quo
);
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [31:0] rem_reg;
    logic [63:0] q_reg;
    logic [32:0] trial;
    logic [32:0] shifted;
    logic [31:0] den_reg;

    assign shifted = {rem_reg, q_reg[63]};
    assign trial   = shifted - {1'b0, den_reg};
    assign quo     = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
                rem_reg  <= '0;
                q_reg    <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                if (!trial[32]) begin
                    rem_reg <= trial[31:0];
                    q_reg   <= {q_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= shifted[31:0];
                    q_reg   <= {q_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/vgrw_datapath.sv
`default_nettype none
module vgrw_datapath #(
    parameter int GRID_X = vgrw_pkg::GRID_X_DEF,
    parameter int GRID_Y = vgrw_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vgrw_pkg::GRID_Z_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_idx,
    input  wire logic [31:0]       cfg_data,
    input  wire logic [191:0]      ray,
    input  wire vgrw_pkg::vgrw_cmd_t cmd,
    output vgrw_pkg::vgrw_sts_t    sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [25:0]            m_data
);
    import vgrw_pkg::*;

    logic signed [31:0] wmin_reg [3];
    logic [30:0]        cs_reg [3];
    logic signed [31:0] dir_reg [3];
    logic signed [32:0] diff_reg [3];
    logic [5:0]         cell_reg [3];
    logic [T_W-1:0]     tmax_reg [3];
    logic [T_W-1:0]     tdel_reg [3];
    logic               neg_reg [3];
    logic               outside_reg;
    logic [5:0]         cnt_reg;
    logic               mv_reg;
    logic [25:0]        md_reg;

    logic [30:0] csx [3];
    logic [31:0] mag [3];
    logic signed [32:0] diff_in [3];
    logic        below_in;
    logic        out_now;
    logic [63:0] dnum;
    logic [31:0] dden;
    logic        ddone;
    logic [63:0] dquo;
    logic [1:0]  ax;
    logic        fin;
    logic [5:0]  nx;
    logic        nx_out;
    logic [5:0]  dims [3];
    logic [11:0] idx;
    logic signed [33:0] num_w;
    logic [T_W:0] tsum;

    assign dims[0] = 6'(GRID_X);
    assign dims[1] = 6'(GRID_Y);
    assign dims[2] = 6'(GRID_Z);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            csx[a] = (cs_reg[a] == '0) ? 31'd1 : cs_reg[a];
            mag[a] = neg_reg[a] ? 32'(-dir_reg[a]) : 32'(dir_reg[a]);
        end
    end

    // origin minus grid corner, any negative axis is outside
    always_comb begin
        below_in = 1'b0;
        for (int a = 0; a < 3; a++) begin
            diff_in[a] = 33'($signed(ray[32*a +: 32])) - 33'(wmin_reg[a]);
            if (diff_in[a] < 0) below_in = 1'b1;
        end
    end

    // divide operand selection
    always_comb begin
        num_w = '0;
        dnum  = '0;
        dden  = {1'b0, csx[cmd.div_axis]};
        if (cmd.div_op == OP_CELL) begin
            dnum = {31'd0, diff_reg[cmd.div_axis]};
        end else if (cmd.div_op == OP_TMAX) begin
            // distance to next edge: cmin = wmin + cell*cs, from diff remainder
            if (neg_reg[cmd.div_axis])
                num_w = 34'(diff_reg[cmd.div_axis])
                      - 34'(cell_reg[cmd.div_axis]) * $signed({3'b0, csx[cmd.div_axis]});
            else
                num_w = 34'($signed({3'b0, csx[cmd.div_axis]}))
                      * 34'(cell_reg[cmd.div_axis] + 6'd1) - 34'(diff_reg[cmd.div_axis]);
            dnum = {14'd0, num_w[33:0], 16'd0};
            dden = mag[cmd.div_axis];
        end else begin
            dnum = {17'd0, csx[cmd.div_axis], 16'd0};
            dden = mag[cmd.div_axis];
        end
    end

    vgrw_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(dnum), .den(dden), .done(ddone), .quo(dquo)
    );

    // start cell past the far edge, seen in the cycle the divide ends
    assign out_now = ddone && (cmd.div_op == OP_CELL)
                  && (dquo >= 64'(dims[cmd.div_axis]));

    always_comb begin
        if (tmax_reg[0] < tmax_reg[1])
            ax = (tmax_reg[0] < tmax_reg[2]) ? 2'd0 : 2'd2;
        else
            ax = (tmax_reg[1] < tmax_reg[2]) ? 2'd1 : 2'd2;
        nx     = neg_reg[ax] ? cell_reg[ax] - 6'd1 : cell_reg[ax] + 6'd1;
        nx_out = (neg_reg[ax] && cell_reg[ax] == 6'd0) || (!neg_reg[ax] && nx >= dims[ax]);
        fin    = (tmax_reg[ax] == T_SAT) || nx_out || (cnt_reg == 6'(RESULT_CAP - 1));
        idx    = 12'(cell_reg[2] * GRID_X * GRID_Y + cell_reg[1] * GRID_X + cell_reg[0]);
        tsum   = {1'b0, tmax_reg[ax]} + {1'b0, tdel_reg[ax]};
    end

    assign sts.div_done = ddone;
    assign sts.outside  = outside_reg || out_now;
    assign sts.fin      = fin;
    assign sts.out_busy = mv_reg && !m_ready;
    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wmin_reg[0] <= -32'sd524288;
            wmin_reg[1] <= -32'sd524288;
            wmin_reg[2] <= -32'sd524288;
            cs_reg[0] <= 31'd65536;
            cs_reg[1] <= 31'd65536;
            cs_reg[2] <= 31'd65536;
            mv_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_WMIN_X: wmin_reg[0] <= cfg_data;
                    REG_WMIN_Y: wmin_reg[1] <= cfg_data;
                    REG_WMIN_Z: wmin_reg[2] <= cfg_data;
                    REG_CS_X:   cs_reg[0] <= cfg_data[30:0];
                    REG_CS_Y:   cs_reg[1] <= cfg_data[30:0];
                    REG_CS_Z:   cs_reg[2] <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cmd.emit || cmd.emit_out) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
        if (cmd.load) begin
            outside_reg <= below_in;
            cnt_reg <= '0;
            for (int a = 0; a < 3; a++) begin
                dir_reg[a]  <= ray[96+32*a +: 32];
                neg_reg[a]  <= ray[96+32*a+31];
                diff_reg[a] <= diff_in[a];
                tmax_reg[a] <= T_SAT;
                tdel_reg[a] <= T_SAT;
            end
        end else if (out_now) begin
            outside_reg <= 1'b1;
        end
        if (ddone) begin
            if (cmd.div_op == OP_CELL) begin
                cell_reg[cmd.div_axis] <= dquo[5:0];
            end else if (dir_reg[cmd.div_axis] != 0) begin
                if (cmd.div_op == OP_TMAX)
                    tmax_reg[cmd.div_axis] <= (dquo > 64'(T_SAT)) ? T_SAT : dquo[T_W-1:0];
                else
                    tdel_reg[cmd.div_axis] <= (dquo > 64'(T_SAT)) ? T_SAT : dquo[T_W-1:0];
            end
        end
        if (cmd.emit)
            md_reg <= {fin, 1'b0, idx, cell_reg[2][3:0], cell_reg[1][3:0], cell_reg[0][3:0]};
        else if (cmd.emit_out)
            md_reg <= {1'b1, 1'b1, 24'd0};
        if (cmd.walk_step) begin
            cnt_reg <= cnt_reg + 6'd1;
            cell_reg[ax] <= nx;
            tmax_reg[ax] <= tsum[T_W] ? T_SAT : tsum[T_W-1:0];
        end
    end
endmodule
`default_nettype wire

### rtl/vgrw_ctrl.sv
`default_nettype none
module vgrw_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire vgrw_pkg::vgrw_sts_t sts,
    output vgrw_pkg::vgrw_cmd_t      cmd
);
    import vgrw_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_WALK, S_DRAIN} state_t;
    state_t     state_reg;
    logic [2:0] op_reg;
    logic [1:0] axis_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = '0;
        cmd.div_op    = op_reg;
        cmd.div_axis  = axis_reg;
        cmd.load      = in_valid && state_reg == S_IDLE;
        cmd.div_start = (state_reg == S_START);
        if (state_reg == S_WALK && !sts.out_busy) begin
            cmd.emit = 1'b1;
            cmd.walk_step = !sts.fin;
        end
        cmd.emit_out = (state_reg == S_DRAIN) && !sts.out_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg <= OP_CELL;
            axis_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (in_valid) begin
                    state_reg <= S_START;
                    op_reg <= OP_CELL;
                    axis_reg <= 2'd0;
                end
                S_START: state_reg <= S_WAIT;
                S_WAIT: if (sts.div_done) begin
                    if (axis_reg != 2'd2) begin
                        axis_reg <= axis_reg + 2'd1;
                        state_reg <= S_START;
                    end else if (op_reg == OP_CELL && sts.outside) begin
                        state_reg <= S_DRAIN;
                    end else if (op_reg == OP_TDEL) begin
                        state_reg <= S_WALK;
                    end else begin
                        op_reg <= op_reg + 3'd1;
                        axis_reg <= 2'd0;
                        state_reg <= S_START;
                    end
                end
                S_WALK: if (!sts.out_busy && sts.fin) state_reg <= S_IDLE;
                S_DRAIN: if (!sts.out_busy) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
